// ----- src/dfs_pkg.sv -----
// ----------------------------------------------------------------------------
// dfs_pkg: shared definitions for the delimiter field splitter
// Widths, register indexes, result kinds, error codes and the result word
// type used by the window cells, the output buffer and the core.
// ----------------------------------------------------------------------------
package dfs_pkg;

    // Field and register widths.
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int SEP_BYTES_W = 64;
    localparam int SEP_BYTES_N = SEP_BYTES_W / BYTE_W;
    localparam int MAXP_W      = 16;
    localparam int MAXL_W      = 20;
    localparam int PLEN_W      = 21;
    localparam int CODE_W      = 2;
    localparam int CFG_ADDR_W  = 2;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 16;

    // Part length saturates here.
    localparam logic [PLEN_W-1:0] LEN_SAT = {PLEN_W{1'b1}};

    // Register reset values.
    localparam logic [LEN_W-1:0]       SEP_LEN_RST   = 4'd1;
    localparam logic [SEP_BYTES_W-1:0] SEP_BYTES_RST = 64'd44;
    localparam logic [MAXP_W-1:0]      MAXP_RST      = 16'hFFFF;
    localparam logic [MAXL_W-1:0]      MAXL_RST      = 20'hFFFFF;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_SEP_LEN   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SEP_BYTES = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_PARTS = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEN   = 2'd3;

    // Result kinds.
    localparam logic [CODE_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [CODE_W-1:0] KIND_BOUND = 2'd1;
    localparam logic [CODE_W-1:0] KIND_DONE  = 2'd2;

    // Error codes reported on the done word.
    localparam logic [CODE_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] ERR_PARTS = 2'd1;
    localparam logic [CODE_W-1:0] ERR_LEN   = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } ctrl_state_t;

    // One result word.
    typedef struct packed {
        logic [CODE_W-1:0] err;
        logic [CODE_W-1:0] kind;
        logic [BYTE_W-1:0] part_byte;
        logic              eor;
    } result_t;

endpackage

// ----- src/delimiter_field_splitter_core.sv -----
// ----------------------------------------------------------------------------
// delimiter_field_splitter_core: splits a byte stream on a literal separator
// Output: a byte or boundary word is registered in the output buffer and shows on
// the m_ side from there. Throughput: one byte word per cycle while the output
// buffer has room; a word with tlast then holds s_tready low during the window
// flush, part close and done word, and those words follow one per cycle while
// the buffer has room. Reset (aresetn low, synchronous) restores register
// defaults and empties the window at once.
// ----------------------------------------------------------------------------
module delimiter_field_splitter_core #(
    parameter int SEP_MAX = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [dfs_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [dfs_pkg::SEP_BYTES_W-1:0]       cfg_wdata,
    // Input stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [dfs_pkg::TDATA_IN_W-1:0]        s_tdata,  // [7:0] data_byte
    input  logic                                  s_tuser,  // [0] byte_present
    input  logic                                  s_tlast,
    // Result stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [dfs_pkg::TDATA_OUT_W-1:0]       m_tdata,  // [7:0] part_byte, [9:8] error_code
    output logic [dfs_pkg::CODE_W-1:0]            m_tuser,  // [1:0] kind
    output logic                                  m_tlast   // end_of_run
);

    localparam int LMAX  = (SEP_MAX < dfs_pkg::SEP_BYTES_N) ? SEP_MAX : dfs_pkg::SEP_BYTES_N;
    localparam int IDX_W = (SEP_MAX > 1) ? $clog2(SEP_MAX) : 1;
    localparam logic [dfs_pkg::LEN_W-1:0] LMAX_V = LMAX[dfs_pkg::LEN_W-1:0];

    // Configuration registers.
    logic [dfs_pkg::LEN_W-1:0]       sep_len_reg;
    logic [dfs_pkg::SEP_BYTES_W-1:0] sep_bytes_reg;
    logic [dfs_pkg::MAXP_W-1:0]      max_parts_reg;
    logic [dfs_pkg::MAXL_W-1:0]      max_len_reg;

    // Text state.
    dfs_pkg::ctrl_state_t            state_reg;
    dfs_pkg::ctrl_state_t            state_next;
    logic [dfs_pkg::LEN_W-1:0]       fill_reg;
    logic [dfs_pkg::LEN_W-1:0]       fill_next;
    logic [dfs_pkg::PLEN_W-1:0]      plen_reg;
    logic [dfs_pkg::PLEN_W-1:0]      plen_next;
    logic [dfs_pkg::MAXP_W-1:0]      pcnt_reg;
    logic [dfs_pkg::MAXP_W-1:0]      pcnt_next;
    logic [dfs_pkg::CODE_W-1:0]      err_reg;
    logic [dfs_pkg::CODE_W-1:0]      err_next;

    // Window cells.
    logic [dfs_pkg::BYTE_W-1:0]      cell_d [SEP_MAX];
    logic [dfs_pkg::BYTE_W-1:0]      cell_q [SEP_MAX];
    logic [SEP_MAX-1:0]              cell_hit;
    logic                            shift_en;
    logic                            match;

    // Derived control values.
    logic                            accept;
    logic                            room;
    logic [dfs_pkg::LEN_W-1:0]       eff_len;
    logic [dfs_pkg::LEN_W-1:0]       len_m1;
    logic [dfs_pkg::LEN_W-1:0]       fill_m1;
    logic [dfs_pkg::LEN_W-1:0]       fill_p1;
    logic [dfs_pkg::PLEN_W-1:0]      plen_inc;
    logic                            parts_full;
    logic                            too_long;
    logic [dfs_pkg::CODE_W-1:0]      err_cnt;
    logic [dfs_pkg::CODE_W-1:0]      err_fin;
    logic [dfs_pkg::CODE_W-1:0]      err_lchk;
    logic [dfs_pkg::MAXP_W-1:0]      pcnt_fin;

    logic                            push;
    dfs_pkg::result_t                push_word;
    dfs_pkg::result_t                pop_word;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == dfs_pkg::ST_RUN) && room;

    // Effective separator length is capped by the window and the byte register.
    assign eff_len  = (sep_len_reg > LMAX_V) ? LMAX_V : sep_len_reg;
    assign len_m1   = eff_len - 4'd1;
    assign fill_m1  = fill_reg - 4'd1;
    assign fill_p1  = fill_reg + 4'd1;
    assign shift_en = accept && s_tuser && (eff_len != '0);
    assign match    = &cell_hit;

    // Row of window cells; the input byte enters cell 0.
    for (genvar k = 0; k < SEP_MAX; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign cell_d[k] = s_tdata[dfs_pkg::BYTE_W-1:0];
        end else begin : g_link
            assign cell_d[k] = cell_q[k-1];
        end
        dfs_cell #(
            .IDX (k)
        ) u_cell (
            .aclk      (aclk),
            .shift_en  (shift_en),
            .din       (cell_d[k]),
            .eff_len   (eff_len),
            .sep_bytes (sep_bytes_reg),
            .dout      (cell_q[k]),
            .hit       (cell_hit[k])
        );
    end

    // Part-close arithmetic shared by the match path and the end of text.
    always_comb begin
        plen_inc   = (plen_reg == dfs_pkg::LEN_SAT) ? plen_reg : plen_reg + 21'd1;
        parts_full = (pcnt_reg >= max_parts_reg);
        pcnt_fin   = parts_full ? pcnt_reg : pcnt_reg + 16'd1;
        err_cnt    = parts_full ? dfs_pkg::ERR_PARTS : err_reg;
        too_long   = (plen_reg > {1'b0, max_len_reg});
        err_fin    = (too_long && (err_cnt == dfs_pkg::ERR_NONE)) ? dfs_pkg::ERR_LEN : err_cnt;
        err_lchk   = (too_long && (err_reg == dfs_pkg::ERR_NONE)) ? dfs_pkg::ERR_LEN : err_reg;
    end

    // Next state and result generation.
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        plen_next  = plen_reg;
        pcnt_next  = pcnt_reg;
        err_next   = err_reg;
        push       = 1'b0;
        push_word  = '0;

        case (state_reg)
            dfs_pkg::ST_RUN: begin
                if (accept) begin
                    if (s_tuser) begin
                        if (eff_len == '0) begin
                            // No separator: every byte passes straight on.
                            push                = 1'b1;
                            push_word.kind      = dfs_pkg::KIND_BYTE;
                            push_word.part_byte = s_tdata[dfs_pkg::BYTE_W-1:0];
                            push_word.eor       = !s_tlast;
                            plen_next           = plen_inc;
                        end else if (fill_p1 == eff_len) begin
                            if (match) begin
                                // Separator found: close the part if it has bytes.
                                if (plen_reg != '0) begin
                                    push           = 1'b1;
                                    push_word.kind = dfs_pkg::KIND_BOUND;
                                    push_word.eor  = !s_tlast;
                                    pcnt_next      = pcnt_fin;
                                    err_next       = err_fin;
                                    plen_next      = '0;
                                end
                                fill_next = '0;
                            end else begin
                                // Oldest window byte can no longer start a match.
                                push                = 1'b1;
                                push_word.kind      = dfs_pkg::KIND_BYTE;
                                push_word.part_byte = cell_d[len_m1[IDX_W-1:0]];
                                push_word.eor       = !s_tlast;
                                plen_next           = plen_inc;
                                fill_next           = len_m1;
                            end
                        end else begin
                            fill_next = fill_p1;
                        end
                    end
                    if (s_tlast) begin
                        state_next = dfs_pkg::ST_FLUSH;
                    end
                end
            end

            dfs_pkg::ST_FLUSH: begin
                if (room) begin
                    if (fill_reg != '0) begin
                        // Drain the window, oldest byte first.
                        push                = 1'b1;
                        push_word.kind      = dfs_pkg::KIND_BYTE;
                        push_word.part_byte = cell_q[fill_m1[IDX_W-1:0]];
                        plen_next           = plen_inc;
                        fill_next           = fill_m1;
                    end else begin
                        if (eff_len == '0) begin
                            // Whole text is one part, even when empty.
                            push           = 1'b1;
                            push_word.kind = dfs_pkg::KIND_BOUND;
                            err_next       = err_lchk;
                            plen_next      = '0;
                        end else if (plen_reg != '0) begin
                            push           = 1'b1;
                            push_word.kind = dfs_pkg::KIND_BOUND;
                            pcnt_next      = pcnt_fin;
                            err_next       = err_fin;
                            plen_next      = '0;
                        end
                        state_next = dfs_pkg::ST_DONE;
                    end
                end
            end

            dfs_pkg::ST_DONE: begin
                if (room) begin
                    push           = 1'b1;
                    push_word.kind = dfs_pkg::KIND_DONE;
                    push_word.err  = err_reg;
                    push_word.eor  = 1'b1;
                    fill_next      = '0;
                    plen_next      = '0;
                    pcnt_next      = '0;
                    err_next       = dfs_pkg::ERR_NONE;
                    state_next     = dfs_pkg::ST_RUN;
                end
            end

            default: begin
                state_next = dfs_pkg::ST_RUN;
            end
        endcase

        // Any configuration write discards the text in progress.
        if (cfg_we) begin
            state_next = dfs_pkg::ST_RUN;
            fill_next  = '0;
            plen_next  = '0;
            pcnt_next  = '0;
            err_next   = dfs_pkg::ERR_NONE;
        end
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dfs_pkg::ST_RUN;
            fill_reg  <= '0;
            plen_reg  <= '0;
            pcnt_reg  <= '0;
            err_reg   <= dfs_pkg::ERR_NONE;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            plen_reg  <= plen_next;
            pcnt_reg  <= pcnt_next;
            err_reg   <= err_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_len_reg   <= dfs_pkg::SEP_LEN_RST;
            sep_bytes_reg <= dfs_pkg::SEP_BYTES_RST;
            max_parts_reg <= dfs_pkg::MAXP_RST;
            max_len_reg   <= dfs_pkg::MAXL_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                dfs_pkg::REG_SEP_LEN:   sep_len_reg   <= cfg_wdata[dfs_pkg::LEN_W-1:0];
                dfs_pkg::REG_SEP_BYTES: sep_bytes_reg <= cfg_wdata;
                dfs_pkg::REG_MAX_PARTS: max_parts_reg <= cfg_wdata[dfs_pkg::MAXP_W-1:0];
                dfs_pkg::REG_MAX_LEN:   max_len_reg   <= cfg_wdata[dfs_pkg::MAXL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Output buffer.
    dfs_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .room      (room),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .pop_word  (pop_word)
    );

    assign m_tdata = {6'b0, pop_word.err, pop_word.part_byte};
    assign m_tuser = pop_word.kind;
    assign m_tlast = pop_word.eor;

endmodule

// ----- src/dfs_cell.sv -----
// ----------------------------------------------------------------------------
// dfs_cell: one byte cell of the separator window
// Holds one text byte, takes its neighbor's byte on a shift and compares
// the byte it is about to hold against its separator byte.
// ----------------------------------------------------------------------------
module dfs_cell #(
    parameter int IDX = 0
) (
    input  logic                                aclk,
    input  logic                                shift_en,
    input  logic [dfs_pkg::BYTE_W-1:0]          din,
    input  logic [dfs_pkg::LEN_W-1:0]           eff_len,
    input  logic [dfs_pkg::SEP_BYTES_W-1:0]     sep_bytes,
    output logic [dfs_pkg::BYTE_W-1:0]          dout,
    output logic                                hit
);

    localparam logic [dfs_pkg::LEN_W:0] IDX_V = IDX[dfs_pkg::LEN_W:0];

    logic [dfs_pkg::BYTE_W-1:0] byte_reg;
    logic                       active;
    logic [dfs_pkg::LEN_W-1:0]  sep_pos;
    logic [dfs_pkg::BYTE_W-1:0] sep_sel;

    // Stored byte moves one cell further on every shift.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= din;
        end
    end

    // The newest byte sits in cell 0, so this cell meets separator byte
    // eff_len-1-IDX once the window is full.
    always_comb begin
        active  = {1'b0, eff_len} > IDX_V;
        sep_pos = eff_len - IDX_V[dfs_pkg::LEN_W-1:0] - 4'd1;
        sep_sel = sep_bytes[sep_pos[2:0]*dfs_pkg::BYTE_W +: dfs_pkg::BYTE_W];
        hit     = !active || (din == sep_sel);
    end

    assign dout = byte_reg;

endmodule

// ----- src/dfs_out_buf.sv -----
// ----------------------------------------------------------------------------
// dfs_out_buf: two-word output buffer
// Decouples result generation from the downstream ready, so a new word can
// be produced while an earlier one still waits to be taken.
// ----------------------------------------------------------------------------
module dfs_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  dfs_pkg::result_t  push_word,
    output logic              room,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dfs_pkg::result_t  pop_word
);

    dfs_pkg::result_t mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             pop;

    assign pop      = m_tvalid && m_tready;
    assign room     = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign pop_word = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule
